// ----- design/gmws_pkg.sv -----
package gmws_pkg;

    localparam int DATA_W             = 32;
    localparam int PROD_W             = 2 * DATA_W;
    localparam int LANES_IN           = 4;
    localparam int OUT_IDX_W          = 6;
    localparam int OUT_TDATA_W        = 8;
    localparam int FUNC_W             = 2;
    localparam int CFG_IDX_W          = 3;
    localparam int OBJ_CNT_W          = 3;
    localparam int DEF_MAX_CANDIDATES = 64;
    localparam int DEF_MAX_OBJECTIVES = 4;

    localparam logic [OBJ_CNT_W-1:0] OBJ_CNT_RESET = 3'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDEAL_0     = 3'd0,
        CFG_IDEAL_1     = 3'd1,
        CFG_IDEAL_2     = 3'd2,
        CFG_IDEAL_3     = 3'd3,
        CFG_OBJ_IN_USE  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // write controls for the candidate row memory and the used-bit memory
    typedef struct packed {
        logic row_we;
        logic used_we;
        logic used_val;
    } store_ctl_t;

    // a - b, saturated to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] d;
        logic signed [DATA_W-1:0] r;
        begin
            d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
            if (d[DATA_W] != d[DATA_W-1])
            begin
                r = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            end
            else
            begin
                r = d[DATA_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

// ----- design/gmws_store.sv -----
module gmws_store
    import gmws_pkg::*;
#(
    parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES,
    parameter int MAX_OBJECTIVES = DEF_MAX_OBJECTIVES,
    parameter int IDX_W          = $clog2(MAX_CANDIDATES),
    parameter int ROW_W          = MAX_OBJECTIVES * DATA_W
)
(
    input  logic             clk,
    input  store_ctl_t       ctl,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [ROW_W-1:0] wr_row,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [ROW_W-1:0] rd_row,
    output logic             rd_used
);

    logic [ROW_W-1:0] row_mem [MAX_CANDIDATES];
    logic             used_mem [MAX_CANDIDATES];

    always_ff @(posedge clk)
    begin
        if (ctl.row_we)
        begin
            row_mem[wr_addr] <= wr_row;
        end
        rd_row <= row_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.used_we)
        begin
            used_mem[wr_addr] <= ctl.used_val;
        end
        rd_used <= used_mem[rd_addr];
    end

endmodule

// ----- design/greedy_minmax_weighted_selection_unit.sv -----
// channel | dir | signals                    | payload
// s       | in  | s_tvalid s_tready          | s_tdata: value_0..value_3; s_tuser: func
// m       | out | m_tvalid m_tready          | m_tdata: chosen_index; m_tuser: found
// cfg     | in  | cfg_we cfg_index cfg_data  | ideal_0..ideal_3, objectives_in_use
//
// Loads and clears keep the unit idle; a load writes the row and used bit a scan reads.
// A query holds s_tready low while it scans the stored candidates through the
// single read port of the candidate memory, drains the pipeline and posts the result.
// Reset clears control and count, zeroes the ideals and sets objectives_in_use to 2.
// A query result waits in the output register; s_tready stays low only while a query runs
// or while a finished query waits behind an untaken result.
module greedy_minmax_weighted_selection_unit
    import gmws_pkg::*;
#(
    parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES,
    parameter int MAX_OBJECTIVES = DEF_MAX_OBJECTIVES
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [LANES_IN*DATA_W-1:0]  s_tdata,   // value_0, value_1, value_2, value_3
    input  logic [FUNC_W-1:0]           s_tuser,   // func
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // chosen_index, zero pad
    output logic                        m_tuser    // found
);

    localparam int IDX_W = $clog2(MAX_CANDIDATES);
    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam int ROW_W = MAX_OBJECTIVES * DATA_W;

    // configuration
    logic signed [DATA_W-1:0] ideal_reg [LANES_IN];
    logic [OBJ_CNT_W-1:0]     obj_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES_IN; i++)
            begin
                ideal_reg[i] <= '0;
            end
            obj_in_use_reg <= OBJ_CNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDEAL_0:    ideal_reg[0] <= cfg_data;
                CFG_IDEAL_1:    ideal_reg[1] <= cfg_data;
                CFG_IDEAL_2:    ideal_reg[2] <= cfg_data;
                CFG_IDEAL_3:    ideal_reg[3] <= cfg_data;
                CFG_OBJ_IN_USE: obj_in_use_reg <= cfg_data[OBJ_CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_addr_reg, scan_addr_next;

    logic accept, load_go, clear_go, query_go, issue, finish_go;
    func_t func;

    assign func     = func_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // per-lane input handling
    logic [ROW_W-1:0]         load_row;
    logic signed [DATA_W-1:0] wt_in [MAX_OBJECTIVES];

    for (genvar k = 0; k < MAX_OBJECTIVES; k++)
    begin : g_lane_in
        if (k < LANES_IN)
        begin : g_real
            assign load_row[k*DATA_W +: DATA_W] = sat_sub(s_tdata[k*DATA_W +: DATA_W],
                                                          ideal_reg[k]);
            assign wt_in[k] = s_tdata[k*DATA_W +: DATA_W];
        end
        else
        begin : g_zero
            assign load_row[k*DATA_W +: DATA_W] = '0;
            assign wt_in[k] = '0;
        end
    end

    // scan pipeline registers
    logic                     rd_valid_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic                     p_valid_reg;
    logic [IDX_W-1:0]         p_idx_reg;
    logic signed [PROD_W-1:0] prod_reg [MAX_OBJECTIVES];
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_idx_reg;
    logic signed [PROD_W-1:0] m_val_reg;
    logic                     have_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic signed [PROD_W-1:0] best_val_reg;
    logic signed [DATA_W-1:0] w_reg [MAX_OBJECTIVES];
    logic [MAX_OBJECTIVES-1:0] lane_on_reg;

    logic                   out_valid_reg;
    logic [OUT_IDX_W-1:0]   out_idx_reg;
    logic                   out_found_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && func == FUNC_QUERY)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_addr_reg == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !p_valid_reg && !m_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        load_go   = accept && (func == FUNC_LOAD) && (count_reg < CNT_W'(MAX_CANDIDATES));
        clear_go  = accept && (func == FUNC_CLEAR);
        query_go  = accept && (func == FUNC_QUERY);
        issue     = (state_reg == ST_SCAN) && (scan_addr_reg != count_reg);
        finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

        count_next = count_reg;
        if (clear_go)
        begin
            count_next = '0;
        end
        else if (load_go)
        begin
            count_next = count_reg + 1'b1;
        end

        scan_addr_next = scan_addr_reg;
        if (query_go)
        begin
            scan_addr_next = '0;
        end
        else if (issue)
        begin
            scan_addr_next = scan_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
        end
    end

    // candidate and used-bit memories
    store_ctl_t        st_ctl;
    logic [IDX_W-1:0]  st_wr_addr;
    logic [ROW_W-1:0]  rd_row;
    logic              rd_used;

    always_comb
    begin
        st_ctl.row_we   = load_go;
        st_ctl.used_we  = load_go || (finish_go && have_reg);
        st_ctl.used_val = !load_go;
        st_wr_addr      = load_go ? count_reg[IDX_W-1:0] : best_idx_reg;
    end

    gmws_store #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .MAX_OBJECTIVES (MAX_OBJECTIVES),
        .IDX_W          (IDX_W),
        .ROW_W          (ROW_W)
    ) u_store (
        .clk     (clk),
        .ctl     (st_ctl),
        .wr_addr (st_wr_addr),
        .wr_row  (load_row),
        .rd_addr (scan_addr_reg[IDX_W-1:0]),
        .rd_row  (rd_row),
        .rd_used (rd_used)
    );

    // query weights and active lanes, latched at the start of a query
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            for (int k = 0; k < MAX_OBJECTIVES; k++)
            begin
                w_reg[k]       <= wt_in[k];
                lane_on_reg[k] <= (k == 0) || (32'(k) < 32'(obj_in_use_reg));
            end
        end
    end

    // lane products, lane max, running minimum
    logic signed [DATA_W-1:0] rd_lane [MAX_OBJECTIVES];
    logic signed [PROD_W-1:0] lane_max;
    logic                     best_take;

    always_comb
    begin
        for (int k = 0; k < MAX_OBJECTIVES; k++)
        begin
            rd_lane[k] = rd_row[k*DATA_W +: DATA_W];
        end
        lane_max = prod_reg[0];
        for (int k = 1; k < MAX_OBJECTIVES; k++)
        begin
            if (lane_on_reg[k] && (prod_reg[k] > lane_max))
            begin
                lane_max = prod_reg[k];
            end
        end
        best_take = m_valid_reg && (!have_reg || (m_val_reg < best_val_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            have_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            p_valid_reg  <= rd_valid_reg && !rd_used;
            m_valid_reg  <= p_valid_reg;
            if (query_go)
            begin
                have_reg <= 1'b0;
            end
            else if (best_take)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_addr_reg[IDX_W-1:0];
        p_idx_reg  <= rd_idx_reg;
        for (int k = 0; k < MAX_OBJECTIVES; k++)
        begin
            prod_reg[k] <= rd_lane[k] * w_reg[k];
        end
        m_idx_reg <= p_idx_reg;
        m_val_reg <= lane_max;
        if (best_take)
        begin
            best_idx_reg <= m_idx_reg;
            best_val_reg <= m_val_reg;
        end
    end

    // result register
    logic [IDX_W+OUT_IDX_W-1:0] best_idx_wide;

    assign best_idx_wide = {{OUT_IDX_W{1'b0}}, best_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            out_idx_reg   <= have_reg ? best_idx_wide[OUT_IDX_W-1:0] : '0;
            out_found_reg <= have_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_IDX_W){1'b0}}, out_idx_reg};
    assign m_tuser  = out_found_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CANDIDATES))
        else $error("candidate count beyond store depth");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!rd_valid_reg && !p_valid_reg && !m_valid_reg))
        else $error("request taken while scan pipeline busy");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_addr_reg <= count_reg))
        else $error("scan address past candidate count");

    a_best_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && have_reg) |-> (CNT_W'(best_idx_reg) < count_reg))
        else $error("selected candidate outside store");

    a_finish_posts: assert property (@(posedge clk) disable iff (!rst_n)
        finish_go |=> (m_tvalid && (m_tuser == $past(have_reg))))
        else $error("finished query not posted");

endmodule
